FILE: rtl/fdf_pkg.sv
// Shared types and constants for the frame duplicate filter.
// Holds the transfer payload structs, the cell probe struct and the hash constants.
// No dependencies.
`default_nettype none

package fdf_pkg;

   localparam int unsigned HASH_W            = 32;
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned HISTORY_SLOTS_DEF = 32;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic              is_duplicate;
      logic [HASH_W-1:0] hash_value;
   } rsp_type;

   typedef struct packed {
      logic              vld;
      logic              match;
      logic [HASH_W-1:0] hash;
   } probe_type;

endpackage

`default_nettype wire

FILE: rtl/fdf_cell.sv
// One history cell: holds a stored frame hash and checks a passing probe against it.
// The probe and its match flag move on to the next cell every cycle.
// Depends on fdf_pkg.
`default_nettype none

module fdf_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             shift_en,
   input  logic                             valid,
   input  logic [fdf_pkg::HASH_W-1:0]       prev_entry,
   output logic [fdf_pkg::HASH_W-1:0]       entry,
   input  fdf_pkg::probe_type               upstream_probe,
   output fdf_pkg::probe_type               downstream_probe
);
   import fdf_pkg::*;

   logic [HASH_W-1:0] entry_ff;
   logic [HASH_W-1:0] entry_in;
   probe_type         probe_ff;
   probe_type         probe_in;

   always_comb begin
      entry_in       = shift_en ? prev_entry : entry_ff;
      probe_in.vld   = upstream_probe.vld;
      probe_in.hash  = upstream_probe.hash;
      probe_in.match = upstream_probe.match |
                       (valid && (entry_ff == upstream_probe.hash));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.vld <= 1'b0;
      end else begin
         probe_ff.vld <= probe_in.vld;
      end
      entry_ff       <= entry_in;
      probe_ff.match <= probe_in.match;
      probe_ff.hash  <= probe_in.hash;
   end

   assign entry            = entry_ff;
   assign downstream_probe = probe_ff;

endmodule

`default_nettype wire

FILE: rtl/frame_duplicate_filter_unit.sv
// Frame duplicate filter top level: FNV-1a hashing, control and the row of history cells.
// Depends on fdf_pkg and fdf_cell.
//
// Frame bytes are taken one per cycle while the unit is idle and folded into a 32-bit
// FNV-1a hash. The last byte of a frame starts a search: the finished hash walks down
// a row of HISTORY_SLOTS cells, one cell per cycle, each cell checking it against one
// stored hash of a recent new frame. A byte that does not end a frame leaves the unit
// ready for the next byte; a byte that ends a frame holds off the next transfer while
// the probe walks down the cell row, and longer while the result output is stalled.
// A new hash enters the first cell and pushes the oldest one out of the last. The result
// is held in an output register until it is taken.
`default_nettype none

module frame_duplicate_filter_unit #(
   parameter int unsigned HISTORY_SLOTS = fdf_pkg::HISTORY_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fdf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fdf_pkg::rsp_type rsp_data
);
   import fdf_pkg::*;

   localparam int unsigned COUNT_W = $clog2(HISTORY_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_POST   = 3'b100
   } state_type;

   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
      return x * FNV_PRIME;
   endfunction

   state_type         state_ff, state_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] probe_hash_ff, probe_hash_in;
   logic              start_ff, start_in;
   logic              dup_ff, dup_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              shift_en;
   logic [HASH_W-1:0] hash_next;
   probe_type         launch_probe;
   probe_type         tail_probe;
   probe_type         cell_probe [HISTORY_SLOTS];
   logic [HASH_W-1:0] cell_entry [HISTORY_SLOTS];
   logic [HISTORY_SLOTS-1:0] cell_valid;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign hash_next = fnv_step(hash_ff, req_data.data_byte);

   assign launch_probe.vld   = start_ff;
   assign launch_probe.match = 1'b0;
   assign launch_probe.hash  = probe_hash_ff;
   assign tail_probe         = cell_probe[HISTORY_SLOTS-1];

   for (genvar g = 0; g < HISTORY_SLOTS; g++) begin : g_cell
      assign cell_valid[g] = (COUNT_W'(g) < count_ff);
      if (g == 0) begin : g_head
         fdf_cell u_cell (
            .clock            (clock),
            .reset            (reset),
            .shift_en         (shift_en),
            .valid            (cell_valid[g]),
            .prev_entry       (probe_hash_ff),
            .entry            (cell_entry[g]),
            .upstream_probe   (launch_probe),
            .downstream_probe (cell_probe[g])
         );
      end else begin : g_body
         fdf_cell u_cell (
            .clock            (clock),
            .reset            (reset),
            .shift_en         (shift_en),
            .valid            (cell_valid[g]),
            .prev_entry       (cell_entry[g-1]),
            .entry            (cell_entry[g]),
            .upstream_probe   (cell_probe[g-1]),
            .downstream_probe (cell_probe[g])
         );
      end
   end

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      probe_hash_in = probe_hash_ff;
      start_in      = 1'b0;
      dup_in        = dup_ff;
      count_in      = count_ff;
      shift_en      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.frame_end) begin
                  probe_hash_in = hash_next;
                  hash_in       = FNV_BASIS;
                  start_in      = 1'b1;
                  state_in      = ST_SEARCH;
               end else begin
                  hash_in = hash_next;
               end
            end
         end
         ST_SEARCH: begin
            if (tail_probe.vld) begin
               dup_in   = tail_probe.match;
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.is_duplicate = dup_ff;
               rsp_data_in.hash_value   = probe_hash_ff;
               if (!dup_ff) begin
                  shift_en = 1'b1;
                  if (count_ff != COUNT_W'(HISTORY_SLOTS)) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= FNV_BASIS;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_hash_ff <= probe_hash_in;
      dup_ff        <= dup_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
